@@ hdl/api_frame_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// api_frame_deframer_defines
// Assertion macros for the API frame deframer.
// ---------------------------------------------------------------------------
`ifndef API_FRAME_DEFRAMER_DEFINES_SVH
`define API_FRAME_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define AFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define AFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define AFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/afd_pkg.sv @@
// ---------------------------------------------------------------------------
// afd_pkg
// Types and constants shared by the API frame deframer modules.
// ---------------------------------------------------------------------------
package afd_pkg;

	localparam logic [7:0] DELIM  = 8'h7E;
	localparam logic [7:0] SUM_OK = 8'hFF;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEN_HI = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_TYPE   = 3'd3,
		PH_DATA   = 3'd4,
		PH_CSUM   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CSUM_ERR = 2'd1,
		ST_LEN_ERR  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_frame_type;
		logic        last;
		status_t     status_code;
		logic [15:0] frame_length;
	} result_t;

endpackage

@@ hdl/api_frame_deframer.sv @@
// Each accepted byte is held in the input register; its result goes to the output register.
// One byte per cycle unless stalled; the parser registers update once per accepted byte.
// The output register has a skid stage, so input stalls only when both slots are full.
// Reset (arst_n low, asynchronous): parser waits for a delimiter, sums and counts clear,
// max_frame_length returns to 65535, and both streams show no valid transfer.
// ---------------------------------------------------------------------------
// api_frame_deframer
// Byte-serial API frame deframer with length and checksum checks.
// ---------------------------------------------------------------------------
`include "api_frame_deframer_defines.svh"

module api_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,      // max_frame_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status_code,
	                                    // [25:10] frame_length, [31:26] zero
	output logic        m_axis_tuser,   // [0] is_frame_type
	output logic        m_axis_tlast
);

	logic [15:0]       max_len_q;
	logic              res_valid;
	logic              res_ready;
	afd_pkg::result_t  res;
	afd_pkg::result_t  out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 16'hFFFF;
		end else if (cfg_wen) begin
			max_len_q <= cfg_wdata;
		end
	end

	afd_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	afd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.frame_length, out_res.status_code, out_res.data_byte};
	assign m_axis_tuser = out_res.is_frame_type;
	assign m_axis_tlast = out_res.last;

	`AFD_ASSERT_SAME(a_stall_holds_input, clk, arst_n, res_valid && !res_ready, !s_axis_tready)
	`AFD_ASSERT_SAME(a_last_not_type, clk, arst_n, m_axis_tvalid && m_axis_tlast, !m_axis_tuser)
	`AFD_ASSERT_SAME(a_status_only_last, clk, arst_n, m_axis_tvalid && !m_axis_tlast,
		m_axis_tdata[9:8] == afd_pkg::ST_OK)
	`AFD_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_wen, max_len_q == $past(cfg_wdata))

endmodule

@@ hdl/afd_fsm.sv @@
// ---------------------------------------------------------------------------
// afd_fsm
// Input register and frame parser: one received byte per cycle unless results stall.
// ---------------------------------------------------------------------------
module afd_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic [15:0]       max_len,
	output logic              res_valid,
	input  logic              res_ready,
	output afd_pkg::result_t  res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	afd_pkg::phase_t   phase_q, phase_d;
	logic [15:0]       len_q, len_d;
	logic [15:0]       left_q, left_d;
	logic [7:0]        sum_q, sum_d;
	logic              res_v;
	logic              adv;

	assign adv       = valid_s1 && (res_ready || !res_v);
	assign in_ready  = !valid_s1 || adv;
	assign res_valid = valid_s1 && res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= afd_pkg::PH_IDLE;
			len_q   <= 16'd0;
			left_q  <= 16'd0;
			sum_q   <= 8'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		left_d  = left_q;
		sum_d   = sum_q;
		res_v   = 1'b0;
		res     = '0;
		unique case (phase_q) inside
			afd_pkg::PH_LEN_HI: begin
				len_d   = {byte_s1, 8'h00};
				phase_d = afd_pkg::PH_LEN_LO;
			end
			afd_pkg::PH_LEN_LO: begin
				len_d = {len_q[15:8], byte_s1};
				if (len_d == 16'd0 || len_d > max_len) begin
					phase_d          = afd_pkg::PH_IDLE;
					res_v            = 1'b1;
					res.last         = 1'b1;
					res.status_code  = afd_pkg::ST_LEN_ERR;
				end else begin
					left_d  = len_d;
					phase_d = afd_pkg::PH_TYPE;
				end
			end
			afd_pkg::PH_TYPE, afd_pkg::PH_DATA: begin
				sum_d             = sum_q + byte_s1;
				left_d            = left_q - 16'd1;
				phase_d           = (left_d == 16'd0) ? afd_pkg::PH_CSUM : afd_pkg::PH_DATA;
				res_v             = 1'b1;
				res.data_byte     = byte_s1;
				res.is_frame_type = (phase_q == afd_pkg::PH_TYPE);
			end
			afd_pkg::PH_CSUM: begin
				sum_d           = sum_q + byte_s1;
				phase_d         = afd_pkg::PH_IDLE;
				res_v           = 1'b1;
				res.last        = 1'b1;
				res.status_code = (sum_d == afd_pkg::SUM_OK) ? afd_pkg::ST_OK
				                                            : afd_pkg::ST_CSUM_ERR;
			end
			default: begin
				if (byte_s1 == afd_pkg::DELIM) begin
					sum_d   = 8'd0;
					left_d  = 16'd0;
					phase_d = afd_pkg::PH_LEN_HI;
				end else begin
					phase_d = afd_pkg::PH_IDLE;
				end
			end
		endcase
		res.frame_length = len_d;
	end

endmodule

@@ hdl/afd_out_buf.sv @@
// ---------------------------------------------------------------------------
// afd_out_buf
// Output register with a skid stage; ready toward the parser is registered.
// ---------------------------------------------------------------------------
module afd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  afd_pkg::result_t  in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output afd_pkg::result_t  out_res
);

	logic              main_valid_q;
	logic              skid_valid_q;
	afd_pkg::result_t  main_q;
	afd_pkg::result_t  skid_q;
	logic              push;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_ready) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= in_res;
			end
		end else if (push) begin
			skid_q <= in_res;
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the API frame deframer. A queue of received bytes
// feeds a bursty stream driver; a byte-level parser model predicts every
// output transfer, and a monitor checks each one field by field under a
// changing tready pattern. The maximum length register is swept across
// several values between idle phases, extremes included.
// ---------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [7:0] data_byte, [9:8] status_code,
	                                  // [25:10] frame_length, [31:26] zero
	logic        m_axis_tuser;        // [0] is_frame_type
	logic        m_axis_tlast;

	logic [7:0]        rx_bytes_q[$];
	afd_pkg::result_t  deframed_exp[$];

	afd_pkg::phase_t   prs_phase = afd_pkg::PH_IDLE;
	logic [15:0] prs_len = '0;
	logic [15:0] prs_left = '0;
	logic [7:0]  prs_sum = '0;
	logic [15:0] max_len = 16'hFFFF;

	logic        hold_tx = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	int          cycle_cnt = 0;
	int          err_count = 0;
	int          gen_max = 65535;
	int          queued_items = 0;
	int          n_bytes_in = 0;
	int          n_data = 0;
	int          n_ok = 0;
	int          n_csum = 0;
	int          n_len = 0;
	int          n_settings = 0;

	api_frame_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("%0t timeout after %0d cycles", $time, cycle_cnt);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic deframe_byte(input logic [7:0] b);
		afd_pkg::result_t r;
		r = '0;
		r.frame_length = prs_len;
		case (prs_phase)
		afd_pkg::PH_LEN_HI: begin
			prs_len = {b, 8'h00};
			prs_phase = afd_pkg::PH_LEN_LO;
		end
		afd_pkg::PH_LEN_LO: begin
			prs_len[7:0] = b;
			if (prs_len == 16'd0 || prs_len > max_len) begin
				prs_phase = afd_pkg::PH_IDLE;
				r.last = 1'b1;
				r.status_code = afd_pkg::ST_LEN_ERR;
				r.frame_length = prs_len;
				deframed_exp.push_back(r);
			end else begin
				prs_left = prs_len;
				prs_phase = afd_pkg::PH_TYPE;
			end
		end
		afd_pkg::PH_TYPE, afd_pkg::PH_DATA: begin
			r.data_byte = b;
			r.is_frame_type = (prs_phase == afd_pkg::PH_TYPE);
			prs_sum = prs_sum + b;
			prs_left = prs_left - 16'd1;
			prs_phase = (prs_left == 16'd0) ? afd_pkg::PH_CSUM : afd_pkg::PH_DATA;
			deframed_exp.push_back(r);
		end
		afd_pkg::PH_CSUM: begin
			prs_sum = prs_sum + b;
			prs_phase = afd_pkg::PH_IDLE;
			r.last = 1'b1;
			r.status_code = (prs_sum == afd_pkg::SUM_OK) ? afd_pkg::ST_OK
			                                             : afd_pkg::ST_CSUM_ERR;
			deframed_exp.push_back(r);
		end
		default: begin
			if (b == afd_pkg::DELIM) begin
				prs_sum = '0;
				prs_left = '0;
				prs_phase = afd_pkg::PH_LEN_HI;
			end else begin
				prs_phase = afd_pkg::PH_IDLE;
			end
		end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// stream driver: bursts of transfers with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (rx_bytes_q.size() != 0 && !hold_tx) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= rx_bytes_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					                                          : $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(20, 300);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((cycle_cnt % 5) < 3);
			endcase
		end
	end

	// monitor and parser model
	always @(posedge clk) begin : mon
		afd_pkg::result_t want;
		if (cfg_wen)
			max_len = cfg_wdata;
		if (m_axis_tvalid && m_axis_tready) begin
			if (deframed_exp.size() == 0) begin
				err_count++;
				$display("%0t unexpected transfer: expected none, actual %0h last %0b",
				         $time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = deframed_exp.pop_front();
				check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
				check_field("status_code", 32'(want.status_code), 32'(m_axis_tdata[9:8]));
				check_field("frame_length", 32'(want.frame_length),
				            32'(m_axis_tdata[25:10]));
				check_field("padding", 32'd0, 32'(m_axis_tdata[31:26]));
				check_field("is_frame_type", 32'(want.is_frame_type), 32'(m_axis_tuser));
				check_field("last", 32'(want.last), 32'(m_axis_tlast));
				if (!want.last)
					n_data++;
				else if (want.status_code == afd_pkg::ST_OK)
					n_ok++;
				else if (want.status_code == afd_pkg::ST_CSUM_ERR)
					n_csum++;
				else
					n_len++;
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			n_bytes_in++;
			deframe_byte(s_axis_tdata);
		end
	end

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return afd_pkg::DELIM;
		if (r == 1)
			return 8'h00;
		if (r == 2)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// cut < 0 sends the whole frame; otherwise only cut body bytes, no checksum
	task automatic push_frame(input logic [15:0] len, input bit bad_sum, input int cut);
		logic [7:0] sum;
		logic [7:0] b;
		int i;
		int n;
		rx_bytes_q.push_back(afd_pkg::DELIM);
		rx_bytes_q.push_back(len[15:8]);
		rx_bytes_q.push_back(len[7:0]);
		sum = '0;
		n = (cut >= 0) ? cut : len;
		for (i = 0; i < n; i++) begin
			b = pick_byte();
			sum = sum + b;
			rx_bytes_q.push_back(b);
		end
		queued_items += n + 3;
		if (cut < 0 && len != 16'd0) begin
			b = afd_pkg::SUM_OK - sum;
			if (bad_sum)
				b = b ^ 8'($urandom_range(1, 255));
			rx_bytes_q.push_back(b);
			queued_items++;
		end
	endtask

	task automatic random_traffic(input int n_items);
		int start;
		int sel;
		int cap;
		int r;
		int i;
		int k;
		logic [15:0] len;
		logic [7:0] b;
		start = queued_items;
		while (queued_items - start < n_items) begin
			sel = $urandom_range(0, 99);
			cap = (gen_max < 600) ? gen_max : 600;
			r = $urandom_range(0, 19);
			if (r == 0)
				len = 16'($urandom_range(1, cap));
			else if (r < 4)
				len = 16'($urandom_range(1, (cap < 64) ? cap : 64));
			else
				len = 16'($urandom_range(1, (cap < 12) ? cap : 12));
			if (sel < 68) begin
				push_frame(len, 1'b0, -1);
			end else if (sel < 78) begin
				push_frame(len, 1'b1, -1);
			end else if (sel < 83) begin
				push_frame(16'd0, 1'b0, -1);
			end else if (sel < 89 && gen_max < 65535) begin
				push_frame(16'($urandom_range(gen_max + 1, 65535)), 1'b0, 0);
			end else if (sel < 91) begin
				push_frame(len, 1'b0, $urandom_range(0, len - 1));
			end else begin
				k = $urandom_range(1, 4);
				for (i = 0; i < k; i++) begin
					do b = 8'($urandom_range(0, 255)); while (b == afd_pkg::DELIM);
					rx_bytes_q.push_back(b);
				end
				queued_items += k;
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (rx_bytes_q.size() != 0 || s_axis_tvalid || deframed_exp.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// complete any partial frame so the parser ends the phase idle
	task automatic flush_parser();
		int i;
		wait_drained();
		while (prs_phase != afd_pkg::PH_IDLE) begin
			case (prs_phase)
			afd_pkg::PH_TYPE, afd_pkg::PH_DATA: begin
				for (i = 0; i < prs_left; i++)
					rx_bytes_q.push_back(8'h00);
				rx_bytes_q.push_back(8'h00);
			end
			default: rx_bytes_q.push_back(8'h00);
			endcase
			wait_drained();
		end
	endtask

	task automatic write_max(input logic [15:0] value);
		wait_drained();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		gen_max = value;
		n_settings++;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic send(input logic [7:0] b);
		rx_bytes_q.push_back(b);
	endtask

	initial begin
		int waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the limit: noise, good frames, zero length, bad checksum
		send(8'h00); send(8'hFF);
		send(afd_pkg::DELIM); send(8'h00); send(8'h01); send(8'h00); send(8'hFF);
		send(afd_pkg::DELIM); send(8'h00); send(8'h02); send(8'hFF);
		send(afd_pkg::DELIM); send(8'h82);
		send(afd_pkg::DELIM); send(8'h00); send(8'h00);
		send(afd_pkg::DELIM); send(8'h00); send(8'h01); send(8'h10); send(8'h10);
		flush_parser();

		// limit of zero rejects everything
		write_max(16'd0);
		send(afd_pkg::DELIM); send(8'h00); send(8'h01);
		send(afd_pkg::DELIM); send(8'hFF); send(8'hFF);
		flush_parser();

		// limit of one
		write_max(16'd1);
		send(afd_pkg::DELIM); send(8'h00); send(8'h01); send(8'h5A); send(8'hA5);
		send(afd_pkg::DELIM); send(8'h00); send(8'h02);
		flush_parser();

		write_max(16'hFFFF);
		push_frame(16'd300, 1'b0, -1);
		random_traffic(250);
		do @(negedge clk); while (rx_bytes_q.size() > 100);
		@(posedge clk);
		hold_tx <= 1'b1;
		do @(negedge clk); while (deframed_exp.size() != 0);
		@(posedge clk);
		hold_tx <= 1'b0;
		random_traffic(250);
		flush_parser();

		write_max(16'($urandom_range(16, 200)));
		random_traffic(350);
		flush_parser();

		write_max(16'd1000);
		random_traffic(350);
		flush_parser();

		write_max(16'd5);
		random_traffic(350);
		flush_parser();

		do @(negedge clk); while (rx_bytes_q.size() != 0 || s_axis_tvalid);
		waited = 0;
		while (deframed_exp.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (deframed_exp.size() != 0) begin
			err_count++;
			$display("%0t %0d expected transfers never arrived", $time, deframed_exp.size());
		end

		$display("Run covered %0d input bytes over %0d limit settings in %0d cycles.",
		         n_bytes_in, n_settings + 1, cycle_cnt);
		$display("Checked %0d data transfers, %0d ok, %0d checksum and %0d length errors.",
		         n_data, n_ok, n_csum, n_len);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
